FILE: hw/rtl/irpds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irpds_pkg;

    // item codes on the mode field
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_START = 2'd2
    } t_mode;

    localparam int unsigned CNT_W      = 13;
    localparam int unsigned UNIT_W     = 8;
    localparam int unsigned ENTRY_W    = 8;
    localparam int unsigned NIB_W      = 4;
    localparam int unsigned IDX_W      = 6;
    localparam logic [UNIT_W-1:0] UNIT_RESET = 8'd21;

    // register word index, taken from paddr[2]
    localparam logic REG_UNIT_TICKS = 1'b0;
    localparam int unsigned PADDR_W = 3;

    typedef struct packed {
        logic [CNT_W-1:0] mark;
        logic [CNT_W-1:0] period;
    } t_limits;

endpackage

`default_nettype wire

FILE: hw/rtl/irpds_limits.sv
`timescale 1ns / 1ps
`default_nettype none

// mark and period lengths in carrier ticks for one table entry
module irpds_limits (
    input  wire logic [irpds_pkg::ENTRY_W-1:0] i_entry,
    input  wire logic [irpds_pkg::UNIT_W-1:0]  i_unit,
    output irpds_pkg::t_limits                  o_limits
);

    localparam int unsigned CW = irpds_pkg::CNT_W;

    logic [irpds_pkg::NIB_W:0]   w_mark_units;
    logic [irpds_pkg::NIB_W:0]   w_space_units;
    logic [irpds_pkg::CNT_W-1:0] w_mark;
    logic [irpds_pkg::CNT_W-1:0] w_space;

    assign w_mark_units  = {1'b0, i_entry[7:4]} + 5'd1;
    assign w_space_units = {1'b0, i_entry[3:0]} + 5'd1;

    // 5 x 8 bits fits the 13-bit counter exactly
    assign w_mark  = CW'(w_mark_units) * CW'(i_unit);
    assign w_space = CW'(w_space_units) * CW'(i_unit);

    assign o_limits.mark   = w_mark;
    assign o_limits.period = w_mark + w_space;

endmodule

`default_nettype wire

FILE: hw/rtl/ir_pulse_distance_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse-distance infrared sequencer (NEC transmitter style). Every input transfer yields
// exactly one result transfer, and the block takes one item per clock cycle: the result
// of an item is computed in the cycle it is accepted and lands in an output register, so
// o_ready stays high while that register is empty or being drained. Items are: a carrier
// tick (mode 0), a table write (mode 1, ignored while busy or past the table), and a
// start (mode 2, ignored while busy). The mark/space table is a TABLE_DEPTH x 8 memory
// with a registered read port; it is always read at the entry after the current one,
// so the next entry sits in the read register before its first possible use. Entries
// that were never written read back as garbage: load every entry from 1 up before a
// start. There is no clearing pass after reset. The base unit length (unit_ticks) is
// the only APB register, at byte address 0; write it only while the block is idle.
module ir_pulse_distance_sequencer #(
    parameter int unsigned TABLE_DEPTH = 34
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // item channel
    input  wire logic                                i_valid,
    output      logic                                o_ready,
    input  wire logic [1:0]                          i_mode,
    input  wire logic [irpds_pkg::IDX_W-1:0]         i_entry_index,
    input  wire logic [irpds_pkg::ENTRY_W-1:0]       i_entry_value,

    // result channel
    output      logic                                o_valid,
    input  wire logic                                i_ready,
    output      logic                                o_carrier_on,
    output      logic                                o_busy_res,
    output      logic                                o_frame_done,

    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [irpds_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                         pwdata,
    output      logic [31:0]                         prdata,
    output      logic                                pready
);

    // memory address width and pointer width (pointer can hold TABLE_DEPTH itself)
    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
    localparam logic [PW:0] DEPTH_P = (PW + 1)'(TABLE_DEPTH);
    localparam logic [irpds_pkg::IDX_W:0] DEPTH_I = (irpds_pkg::IDX_W + 1)'(TABLE_DEPTH);
    localparam int unsigned CW = irpds_pkg::CNT_W;

    // timing table memory and its read register
    logic [irpds_pkg::ENTRY_W-1:0] r_table [0:TABLE_DEPTH-1];
    logic [irpds_pkg::ENTRY_W-1:0] r_rd_data;

    // sequencer state
    logic [irpds_pkg::UNIT_W-1:0] r_unit_ticks;
    logic [PW-1:0]                r_ptr,    n_ptr;
    logic [CW-1:0]                r_pass,   n_pass;
    logic [CW-1:0]                r_mark,   n_mark;
    logic [CW-1:0]                r_period, n_period;
    logic                         r_final,  n_final;
    logic                         r_gate,   n_gate;
    logic                         r_run,    n_run;

    // output register
    logic r_out_valid;
    logic r_out_carrier;
    logic r_out_busy;
    logic r_out_done;

    logic                 w_in_xfer;
    logic                 w_cfg_wr;
    logic                 w_we;
    logic                 w_done;
    logic [PW:0]          w_next_ptr;
    logic [AW-1:0]        w_rd_addr;
    irpds_pkg::t_limits   w_limits;

    // output register frees up when it is empty or drained this cycle
    assign o_ready   = !r_out_valid || i_ready;
    assign w_in_xfer = i_valid && o_ready;

    // the entry after the current one is what the next period boundary loads
    assign w_next_ptr = {1'b0, r_ptr} + (PW + 1)'(1);
    assign w_rd_addr  = (w_next_ptr < DEPTH_P) ? w_next_ptr[AW-1:0] : '0;

    irpds_limits u_limits (
        .i_entry  (r_rd_data),
        .i_unit   (r_unit_ticks),
        .o_limits (w_limits)
    );

    // next-state logic, in the order the sequencer defines it:
    // mark end (possibly frame end) first, then period boundary
    always_comb begin
        n_ptr    = r_ptr;
        n_pass   = r_pass;
        n_mark   = r_mark;
        n_period = r_period;
        n_final  = r_final;
        n_gate   = r_gate;
        n_run    = r_run;
        w_done   = 1'b0;
        w_we     = 1'b0;
        if (w_in_xfer) begin
            case (i_mode)
                irpds_pkg::MODE_TICK: begin
                    if (r_run) begin
                        n_pass = r_pass + CW'(1);
                        if (n_pass == r_mark) begin
                            n_gate = 1'b0;
                            if (r_final) begin
                                // frame end: back to idle, counters re-armed
                                n_run    = 1'b0;
                                n_pass   = '0;
                                n_ptr    = '0;
                                n_mark   = CW'(1);
                                n_period = CW'(1);
                                n_final  = 1'b0;
                                w_done   = 1'b1;
                            end
                        end
                        // after a frame end the pass count is zero and the period one,
                        // so no boundary can follow on the same tick
                        if (n_pass == n_period) begin
                            if (w_next_ptr < DEPTH_P) begin
                                n_mark   = w_limits.mark;
                                n_period = w_limits.period;
                            end else begin
                                // past the last entry: one closing mark of a single unit
                                n_final = 1'b1;
                                n_mark  = {{(CW - irpds_pkg::UNIT_W){1'b0}}, r_unit_ticks};
                            end
                            n_ptr  = w_next_ptr[PW-1:0];
                            n_pass = '0;
                            n_gate = 1'b1;
                        end
                    end
                end
                irpds_pkg::MODE_WRITE: begin
                    if (!r_run && ({1'b0, i_entry_index} < DEPTH_I)) begin
                        w_we = 1'b1;
                    end
                end
                irpds_pkg::MODE_START: begin
                    if (!r_run) begin
                        n_pass   = '0;
                        n_ptr    = '0;
                        n_mark   = CW'(1);
                        n_period = CW'(1);
                        n_final  = 1'b0;
                        n_gate   = 1'b0;
                        n_run    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[i_entry_index[AW-1:0]] <= i_entry_value;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_pass   <= '0;
            r_mark   <= CW'(1);
            r_period <= CW'(1);
            r_final  <= 1'b0;
            r_gate   <= 1'b0;
            r_run    <= 1'b0;
        end else begin
            r_ptr    <= n_ptr;
            r_pass   <= n_pass;
            r_mark   <= n_mark;
            r_period <= n_period;
            r_final  <= n_final;
            r_gate   <= n_gate;
            r_run    <= n_run;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_carrier <= n_gate;
            r_out_busy    <= n_run;
            r_out_done    <= w_done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_carrier_on = r_out_carrier;
    assign o_busy_res   = r_out_busy;
    assign o_frame_done = r_out_done;

    // configuration port: zero wait states, byte lanes within the word ignored
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= irpds_pkg::UNIT_RESET;
        end else if (w_cfg_wr && (paddr[2] == irpds_pkg::REG_UNIT_TICKS)) begin
            r_unit_ticks <= pwdata[irpds_pkg::UNIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == irpds_pkg::REG_UNIT_TICKS)
                  ? {{(32 - irpds_pkg::UNIT_W){1'b0}}, r_unit_ticks} : 32'd0;

endmodule

`default_nettype wire

FILE: hw/rtl/irpds_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module irpds_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_ready,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_carrier_on,
    input wire logic                          o_busy_res,
    input wire logic                          o_frame_done
);

    // carrier is only gated on inside a transmission
    a_carrier_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_carrier_on |-> o_busy_res)
        else $error("carrier on while not busy");

    // frame end leaves the block idle with the carrier off
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> !o_busy_res && !o_carrier_on)
        else $error("frame end while still busy or gated");

    // input side never stalls while no result is pending
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_carrier_on) && $stable(o_busy_res)
                                 && $stable(o_frame_done))
        else $error("result changed while stalled");

endmodule

bind ir_pulse_distance_sequencer irpds_checker u_irpds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_carrier_on (o_carrier_on),
    .o_busy_res   (o_busy_res),
    .o_frame_done (o_frame_done)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned TABLE_DEPTH = 34;
    localparam int unsigned UNIT_W  = irpds_pkg::UNIT_W;
    localparam int unsigned ENTRY_W = irpds_pkg::ENTRY_W;
    localparam int unsigned NIB_W   = irpds_pkg::NIB_W;
    localparam int unsigned IDX_W   = irpds_pkg::IDX_W;
    localparam int unsigned CNT_W   = irpds_pkg::CNT_W;
    localparam int unsigned PADDR_W = irpds_pkg::PADDR_W;
    // the mode field's spare code, ignored by the block
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [PADDR_W-1:0] UNIT_TICKS_ADDR = {irpds_pkg::REG_UNIT_TICKS, 2'b00};
    localparam int unsigned ITEM_TARGET = 1250;

    // ways of filling the mark/space table
    typedef enum int {
        FILL_MIXED,
        FILL_SHORTEST,
        FILL_SHORT_RANDOM
    } t_fill;

    // what one result transfer carries
    typedef struct packed {
        logic carrier_on;
        logic busy;
        logic frame_done;
    } t_ir_status;

    // predicts the carrier gate and busy/done flags, one status per item transfer
    class ir_gate_predictor;
        logic [UNIT_W-1:0]  unit_ticks;
        logic [ENTRY_W-1:0] timing [64];
        logic [IDX_W-1:0]   entry_ptr;
        logic [CNT_W-1:0]   pass_cnt;
        logic [CNT_W-1:0]   mark_lim;
        logic [CNT_W-1:0]   period_lim;
        logic               final_mark;
        logic               gate;
        logic               running;
        t_ir_status         status_q[$];
        int unsigned        errors;

        function new();
            unit_ticks = irpds_pkg::UNIT_RESET;
            foreach (timing[i]) timing[i] = '0;
            rearm();
            gate     = 1'b0;
            running  = 1'b0;
            errors   = 0;
        endfunction

        function void rearm();
            pass_cnt   = '0;
            entry_ptr  = '0;
            mark_lim   = CNT_W'(1);
            period_lim = CNT_W'(1);
            final_mark = 1'b0;
        endfunction

        // one carrier period; returns 1 when the closing mark ends
        function logic advance_tick();
            logic               done;
            int unsigned        nxt;
            logic [ENTRY_W-1:0] e;
            logic [CNT_W-1:0]   m;
            logic [CNT_W-1:0]   s;
            done = 1'b0;
            if (!running) return 1'b0;
            pass_cnt = pass_cnt + CNT_W'(1);
            if (pass_cnt == mark_lim) begin
                gate = 1'b0;
                if (final_mark) begin
                    running = 1'b0;
                    rearm();
                    done = 1'b1;
                end
            end
            if (pass_cnt == period_lim) begin
                nxt = entry_ptr + 1;
                if (nxt < TABLE_DEPTH) begin
                    e = timing[nxt];
                    m = CNT_W'((e[ENTRY_W-1:NIB_W] + 32'd1) * unit_ticks);
                    s = CNT_W'((e[NIB_W-1:0] + 32'd1) * unit_ticks);
                    mark_lim   = m;
                    period_lim = s + m;
                end else begin
                    final_mark = 1'b1;
                    mark_lim   = CNT_W'(unit_ticks);
                end
                entry_ptr = IDX_W'(nxt);
                pass_cnt  = '0;
                gate      = 1'b1;
            end
            return done;
        endfunction

        function void apply_item(logic [1:0] mode, logic [IDX_W-1:0] idx,
                                 logic [ENTRY_W-1:0] val);
            t_ir_status st;
            st.frame_done = 1'b0;
            case (mode)
                irpds_pkg::MODE_TICK: begin
                    st.frame_done = advance_tick();
                end
                irpds_pkg::MODE_WRITE: begin
                    if (!running && idx < TABLE_DEPTH) timing[idx] = val;
                end
                irpds_pkg::MODE_START: begin
                    if (!running) begin
                        rearm();
                        gate    = 1'b0;
                        running = 1'b1;
                    end
                end
                default: ;
            endcase
            st.carrier_on = gate;
            st.busy       = running;
            status_q.push_back(st);
        endfunction

        function void report(string what, logic exp_v, logic act_v);
            errors++;
            $display("%0t %s mismatch: expected %0b, got %0b", $time, what, exp_v, act_v);
        endfunction

        function void check_status(logic carrier_on, logic busy, logic frame_done);
            t_ir_status want;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t result transfer with nothing outstanding", $time);
                return;
            end
            want = status_q.pop_front();
            if (carrier_on !== want.carrier_on) report("carrier_on", want.carrier_on, carrier_on);
            if (busy !== want.busy) report("busy_res", want.busy, busy);
            if (frame_done !== want.frame_done) report("frame_done", want.frame_done, frame_done);
        endfunction

        function void check_unit_readback(logic [31:0] rdata);
            if (rdata[UNIT_W-1:0] !== unit_ticks) begin
                errors++;
                $display("%0t unit_ticks readback: expected %0d, got %0d",
                         $time, unit_ticks, rdata[UNIT_W-1:0]);
            end
        endfunction

        function int unsigned pending();
            return status_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_mode = irpds_pkg::MODE_TICK;
    logic [IDX_W-1:0]     i_entry_index = '0;
    logic [ENTRY_W-1:0]   i_entry_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b1;
    logic                 o_carrier_on;
    logic                 o_busy_res;
    logic                 o_frame_done;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    ir_gate_predictor sb = new();

    // sender burst state, receiver stall state
    int unsigned burst_left = 0;
    int unsigned sent_items = 0;
    int unsigned stall_left = 0;
    int unsigned stall_style = 0;
    logic [7:0]  stall_mask = 8'hFF;

    ir_pulse_distance_sequencer #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_carrier_on  (o_carrier_on),
        .o_busy_res    (o_busy_res),
        .o_frame_done  (o_frame_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // result side: stalls follow a randomly drawn style, redrawn whenever its countdown runs out
    // (always ready, coin flip, mostly stalled, rotating mask)
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(8, 200);
            stall_mask  = 8'($urandom_range(1, 255));
        end else begin
            stall_left--;
        end
        if (stall_style == 0)
            i_ready = 1'b1;
        else if (stall_style == 1)
            i_ready = 1'($urandom_range(0, 1));
        else if (stall_style == 2)
            i_ready = ($urandom_range(0, 3) == 0);
        else
            i_ready = stall_mask[stall_left[2:0]];
    end

    // every result transfer is checked against the oldest predicted status
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_status(o_carrier_on, o_busy_res, o_frame_done);
    end

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [ENTRY_W-1:0] rand_val();
        return ENTRY_W'($urandom_range(0, 255));
    endfunction

    // one item transfer; valid stays high across a burst, a gap may open between bursts
    task automatic send_item(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [ENTRY_W-1:0] val);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_mode        = mode;
        i_entry_index = idx;
        i_entry_value = val;
        do @(posedge i_clk); while (!o_ready);
        sent_items++;
        sb.apply_item(mode, idx, val);
        if (burst_left != 0) burst_left--;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // setup cycle then access cycle; pready is sampled at the access edge
    task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = UNIT_TICKS_ADDR;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // unit length changes only once the block has drained and gone quiet
    task automatic program_unit(input logic [UNIT_W-1:0] unit);
        logic [31:0] rdata;
        drop_valid();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_transfer(1'b1, {{(32-UNIT_W){1'b0}}, unit}, rdata);
        sb.unit_ticks = unit;
        apb_transfer(1'b0, '0, rdata);
        sb.check_unit_readback(rdata);
    endtask

    // mostly short marks and spaces so that frames stay brief
    function automatic logic [ENTRY_W-1:0] short_entry();
        if ($urandom_range(0, 99) < 15) return ENTRY_W'($urandom_range(0, 255));
        return {NIB_W'($urandom_range(0, 1)), NIB_W'($urandom_range(0, 2))};
    endfunction

    // writes every table position, entry 0 included
    task automatic load_table(input t_fill fill);
        logic [ENTRY_W-1:0] val;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (fill)
                FILL_MIXED: begin
                    if (i <= 1) val = 8'hFF;
                    else if (i == 2) val = 8'h00;
                    else if (i == 3) val = 8'hF0;
                    else if (i == 4) val = 8'h0F;
                    else val = i[0] ? 8'h10 : 8'h01;
                end
                FILL_SHORTEST: val = 8'h00;
                default:       val = short_entry();
            endcase
            send_item(irpds_pkg::MODE_WRITE, IDX_W'(i), val);
        end
    endtask

    // start, poke the busy block, then tick until the closing mark ends
    task automatic run_frame(input int unsigned noise_pct);
        send_item(irpds_pkg::MODE_START, rand_idx(), rand_val());
        // start, table write and spare code while busy: all ignored
        send_item(irpds_pkg::MODE_START, rand_idx(), rand_val());
        send_item(irpds_pkg::MODE_WRITE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_val());
        send_item(MODE_NONE, rand_idx(), rand_val());
        while (sb.running) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(2'($urandom_range(irpds_pkg::MODE_WRITE, MODE_NONE)), rand_idx(),
                          rand_val());
            else
                send_item(irpds_pkg::MODE_TICK, rand_idx(), rand_val());
        end
        // tick after the frame: idle, nothing moves
        send_item(irpds_pkg::MODE_TICK, rand_idx(), rand_val());
    endtask

    initial begin
        logic [31:0] rdata;
        int unsigned n;
        int unsigned pick;
        int unsigned drain;

        // synchronous reset, released at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset value of the unit length
        apb_transfer(1'b0, '0, rdata);
        sb.check_unit_readback(rdata);

        // idle tick, spare code, writes past the table
        send_item(irpds_pkg::MODE_TICK, 6'h3F, 8'hFF);
        send_item(MODE_NONE, 6'h2A, 8'h55);
        send_item(irpds_pkg::MODE_WRITE, IDX_W'(TABLE_DEPTH), 8'h5A);
        send_item(irpds_pkg::MODE_WRITE, 6'h3F, 8'hA5);

        // nibble extremes in the table at the shortest unit
        program_unit(8'd1);
        load_table(FILL_MIXED);
        run_frame(0);

        // shortest entries at a longer unit
        program_unit(8'd4);
        load_table(FILL_SHORTEST);
        run_frame(5);

        // random part: short frames with random content, noise around them
        program_unit(8'd2);
        load_table(FILL_SHORT_RANDOM);
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0)
                program_unit(UNIT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(3, 6)
                                                                 : $urandom_range(1, 2)));
            n = $urandom_range(0, 10);
            repeat (n) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_item(irpds_pkg::MODE_WRITE, IDX_W'($urandom_range(1, TABLE_DEPTH - 1)),
                              short_entry());
                else if (pick == 6)
                    send_item(irpds_pkg::MODE_WRITE, IDX_W'($urandom_range(TABLE_DEPTH, 63)),
                              rand_val());
                else if (pick == 7)
                    send_item(irpds_pkg::MODE_WRITE, '0, rand_val());
                else if (pick == 8)
                    send_item(irpds_pkg::MODE_TICK, rand_idx(), rand_val());
                else
                    send_item(MODE_NONE, rand_idx(), rand_val());
            end
            run_frame(10);
        end

        // drain, then let the bench go quiet before the final check
        drop_valid();
        drain = 0;
        while (sb.pending() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t %0d predicted results never arrived", $time, sb.pending());
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
